>>> hw/rtl/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg: shared types and codes of the min-heap priority queue
// Word formats of the request and response channels, operation and status
// codes, and the flag group that the compare unit hands to the engine.
// ============================================================================
package mhpq_pkg;

   localparam int KEY_W  = 32;
   localparam int FILL_W = 11;

   typedef logic [1:0]              op_code_type;
   typedef logic [1:0]              status_type;
   typedef logic signed [KEY_W-1:0] key_type;

   localparam op_code_type OP_INSERT  = 2'd0;
   localparam op_code_type OP_EXTRACT = 2'd1;
   localparam op_code_type OP_PEEK    = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam key_type KEY_EMPTY = -32'sd1;
   localparam key_type KEY_NONE  = 32'sd0;

   typedef struct packed {
      op_code_type op;
      key_type     key_in;
   } req_word_type;

   typedef struct packed {
      key_type           key_out;
      status_type        status;
      logic [FILL_W-1:0] fill_count;
   } rsp_word_type;

   // compare unit outcome
   typedef struct packed {
      logic sel_c;     // second candidate is in use and strictly smaller than the first
      logic win_lt_a;  // chosen candidate strictly below the moving key
      logic a_lt_win;  // moving key strictly below the chosen candidate
   } cmp_flags_type;

   // engine to top level handshake
   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

>>> hw/rtl/mhpq_cmp.sv
// ============================================================================
// mhpq_cmp: shared signed compare unit
// Picks the smaller of two candidate keys (first one on ties) and compares
// the pick against the moving key in both directions.
// ============================================================================
module mhpq_cmp
   import mhpq_pkg::*;
(
   input  key_type       hole_key,
   input  key_type       cand_b,
   input  key_type       cand_c,
   input  logic          use_c,
   output key_type       win_key,
   output cmp_flags_type flags
);

   logic sel_c;

   assign sel_c          = use_c && (cand_c < cand_b);
   assign win_key        = sel_c ? cand_c : cand_b;
   assign flags.sel_c    = sel_c;
   assign flags.win_lt_a = win_key < hole_key;
   assign flags.a_lt_win = hole_key < win_key;

endmodule

>>> hw/rtl/mhpq_engine.sv
// ============================================================================
// mhpq_engine: heap memory and sift sequencer
// Holds the key array and the entry count, and walks one operation through
// sift-up, sift-down or a root read, one tree level per read state and compare state, using
// the shared compare unit. The moving key rides in a register; only its final
// slot is written with it.
// ============================================================================
module mhpq_engine
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  req_word_type   cmd,
   input  logic           take,
   output eng_status_type eng_status,
   output rsp_word_type   result
);

   localparam int IW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int LW = IW + 1;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_UP_RD  = 8'b0000_0010,
      S_UP_CMP = 8'b0000_0100,
      S_EX_RD  = 8'b0000_1000,
      S_EX_LD  = 8'b0001_0000,
      S_DN_RD  = 8'b0010_0000,
      S_DN_CMP = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   key_type     hole_ff, hole_in;
   op_code_type op_ff, op_in;
   logic        rok_ff, rok_in;
   key_type     res_key_ff, res_key_in;
   status_type  res_status_ff, res_status_in;

   key_type       heap_mem [HEAP_DEPTH];
   key_type       rd_a_ff, rd_b_ff;
   logic [IW-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic          wr_en;
   key_type       wr_data;

   logic [IW-1:0] parent;
   logic [LW-1:0] left, right, count_ext;

   logic          use_c;
   key_type       win_key;
   cmp_flags_type flags;

   assign parent    = (pos_ff - IW'(1)) >> 1;
   assign left      = {pos_ff, 1'b1};
   assign right     = left + LW'(1);
   assign count_ext = LW'(count_ff);

   mhpq_cmp u_cmp (
      .hole_key (hole_ff),
      .cand_b   (rd_a_ff),
      .cand_c   (rd_b_ff),
      .use_c    (use_c),
      .win_key  (win_key),
      .flags    (flags)
   );

   // key array: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      hole_in       = hole_ff;
      op_in         = op_ff;
      rok_in        = rok_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = hole_ff;
      use_c         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = cmd.op;
               res_key_in    = KEY_NONE;
               res_status_in = ST_OK;
               case (cmd.op)
                  OP_INSERT: begin
                     if (count_ff >= CW'(HEAP_DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        hole_in  = cmd.key_in;
                        pos_in   = IW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_RD;
                     end
                  end
                  OP_EXTRACT, OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_key_in    = KEY_EMPTY;
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_EX_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (flags.a_lt_win) begin
               wr_data  = rd_a_ff;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EX_RD: begin
            rd_addr_b = IW'(count_ff - CW'(1));
            state_in  = S_EX_LD;
         end
         S_EX_LD: begin
            res_key_in = rd_a_ff;
            if (op_ff == OP_PEEK) begin
               state_in = S_DONE;
            end else begin
               hole_in  = rd_b_ff;
               count_in = count_ff - CW'(1);
               pos_in   = '0;
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (left >= count_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = left[IW-1:0];
               rd_addr_b = right[IW-1:0];
               rok_in    = right < count_ext;
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            use_c = rok_ff;
            wr_en = 1'b1;
            if (flags.win_lt_a) begin
               wr_data  = win_key;
               pos_in   = flags.sel_c ? right[IW-1:0] : left[IW-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff        <= pos_in;
      hole_ff       <= hole_in;
      op_ff         <= op_in;
      rok_ff        <= rok_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
   end

   assign eng_status.idle   = (state_ff == S_IDLE);
   assign eng_status.done   = (state_ff == S_DONE);
   assign result.key_out    = res_key_ff;
   assign result.status     = res_status_ff;
   assign result.fill_count = FILL_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("entry count above capacity");

   a_up_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP_RD |-> CW'(pos_ff) < count_ff)
      else $error("sift-up slot outside the heap");

   a_dn_child: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DN_CMP |-> left < count_ext)
      else $error("sift-down compare without a left child");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && cmd.op == OP_INSERT
       && count_ff < CW'(HEAP_DEPTH)) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the heap by one");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == ST_EMPTY) |-> count_ff == '0)
      else $error("empty status with keys held");

endmodule

>>> hw/rtl/min_heap_priority_queue.sv
// ============================================================================
// min_heap_priority_queue: binary min-heap of signed 32-bit keys
// Insert, extract-minimum and peek-minimum on a fixed-capacity heap, one
// operation at a time, with a registered response word.
// ============================================================================
//
//  Channel   Dir  Handshake            Word
//  req_      in   req_valid/req_stall  req_word_type (op, key_in)
//  rsp_      out  rsp_valid/rsp_stall  rsp_word_type (key_out, status, fill_count)
//
//  The sift loop spends one read state and one compare state per tree level:
//  insert climbs one parent per swap, extract sinks one child per swap, peek
//  only reads the root, and empty/full/undefined words go straight to done.
//  Reset clears the count and the sequencer; the key array needs no clearing.
//  req_stall is high whenever the sequencer is busy; a finished word waits in
//  the response register while the next request is already being taken.
//
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   eng_status_type eng_status;
   rsp_word_type   eng_result;
   logic           start;
   logic           load;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   // take a request only while the sequencer sits idle
   assign req_stall = !eng_status.idle;
   assign start     = req_valid && !req_stall;

   // move a finished word into the response register once it is free
   assign load = eng_status.done && (!rsp_valid_ff || !rsp_stall);

   mhpq_engine #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_word),
      .take       (load),
      .eng_status (eng_status),
      .result     (eng_result)
   );

   always_comb begin
      // hold while stalled, drop once taken, refill from the engine
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = load ? eng_result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> verif/min_heap_priority_queue_tb.sv
// ============================================================================
// min_heap_priority_queue_tb: self-checking bench of the min-heap queue
// Drives insert, extract-minimum, peek-minimum and undefined operation words
// under several idle and stall patterns. Every response word is checked against
// a hand-typed value or a software heap kept in step with the accepted requests.
// ============================================================================
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;
   import mhpq_pkg::*;

   localparam int HEAP_DEPTH = 1024;

   // code that the block treats as a no-op
   localparam op_code_type OP_UNDEF = 2'd3;

   localparam key_type KEY_MAX  = 32'sh7FFF_FFFF;
   localparam key_type KEY_MIN  = 32'sh8000_0000;
   localparam key_type KEY_JUNK = 32'sh5A5A_5A5A;  // filler for ignored key fields

   // per-phase idle and stall rates, in percent
   localparam int N_MODES = 4;
   localparam int GAP_PCT   [N_MODES] = '{0, 73, 0, 30};
   localparam int STALL_PCT [N_MODES] = '{0, 0, 73, 30};
   localparam int PHASE_ITEMS = 240;

   typedef struct {
      req_word_type req;
      bit           known;   // response typed in by hand
      rsp_word_type rsp;
   } dir_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // shadow heap that the predictor keeps in step with the block
   key_type      heap_keys [HEAP_DEPTH];
   int unsigned  heap_fill = 0;

   rsp_word_type rsp_due_q [$];    // response words owed by the block, oldest first
   dir_row_type  dir_rows  [$];
   int           fault_count = 0;
   int           gap_pct     = 0;
   int           stall_pct   = 0;

   min_heap_priority_queue #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Apply one request word to the shadow heap and return the response the
   // block owes for it. Sift-up stops at a parent that is not strictly
   // greater; sift-down takes the left child on a tie and stops unless the
   // chosen child is strictly smaller.
   function automatic rsp_word_type heap_apply(input req_word_type w);
      rsp_word_type r;
      int unsigned  pos;
      int unsigned  up;
      int unsigned  lc;
      int unsigned  pick;
      bit           moving;
      key_type      tmp;
      r.key_out = KEY_NONE;
      r.status  = ST_OK;
      case (w.op)
         OP_INSERT: begin
            if (heap_fill >= HEAP_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = heap_fill;
               heap_keys[pos] = w.key_in;
               heap_fill++;
               moving = 1'b1;
               while (moving && pos > 0) begin
                  up = (pos - 1) / 2;
                  if (heap_keys[up] <= heap_keys[pos]) begin
                     moving = 1'b0;
                  end else begin
                     tmp = heap_keys[up];
                     heap_keys[up] = heap_keys[pos];
                     heap_keys[pos] = tmp;
                     pos = up;
                  end
               end
            end
         end
         OP_EXTRACT, OP_PEEK: begin
            if (heap_fill == 0) begin
               r.key_out = KEY_EMPTY;
               r.status  = ST_EMPTY;
            end else begin
               r.key_out = heap_keys[0];
               if (w.op == OP_EXTRACT) begin
                  heap_fill--;
                  heap_keys[0] = heap_keys[heap_fill];
                  pos = 0;
                  moving = 1'b1;
                  while (moving) begin
                     lc = 2 * pos + 1;
                     if (lc >= heap_fill) begin
                        moving = 1'b0;
                     end else begin
                        pick = lc;
                        if (lc + 1 < heap_fill && heap_keys[lc + 1] < heap_keys[lc]) begin
                           pick = lc + 1;
                        end
                        if (heap_keys[pick] >= heap_keys[pos]) begin
                           moving = 1'b0;
                        end else begin
                           tmp = heap_keys[pick];
                           heap_keys[pick] = heap_keys[pos];
                           heap_keys[pos] = tmp;
                           pos = pick;
                        end
                     end
                  end
               end
            end
         end
         default: ;  // undefined op leaves everything as it is
      endcase
      r.fill_count = heap_fill[FILL_W-1:0];
      return r;
   endfunction

   // Keys: full range, a narrow band for plenty of ties, the extremes and the two response codes.
   function automatic key_type rand_key();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return key_type'($urandom);
      if (sel < 85) return key_type'(int'($urandom_range(0, 16)) - 8);
      case ($urandom_range(0, 3))
         0:       return KEY_MAX;
         1:       return KEY_MIN;
         2:       return KEY_NONE;
         default: return KEY_EMPTY;
      endcase
   endfunction

   // ins_pct sets the drift: above about 45 the heap grows, below it drains.
   function automatic req_word_type rand_word(input int ins_pct);
      req_word_type w;
      int unsigned  sel;
      sel = $urandom_range(0, 99);
      w.key_in = rand_key();
      if (sel < ins_pct)   w.op = OP_INSERT;
      else if (sel < 90)   w.op = OP_EXTRACT;
      else if (sel < 96)   w.op = OP_PEEK;
      else                 w.op = OP_UNDEF;
      return w;
   endfunction

   task automatic add_row(input op_code_type op, input key_type key,
                          input bit known = 1'b0, input key_type k_out = KEY_NONE,
                          input status_type st = ST_OK, input int fill = 0);
      dir_row_type row;
      row.req.op          = op;
      row.req.key_in      = key;
      row.known           = known;
      row.rsp.key_out     = k_out;
      row.rsp.status      = st;
      row.rsp.fill_count  = FILL_W'(fill);
      dir_rows.push_back(row);
   endtask

   // Present one request word, hold it until taken, then predict its response.
   // Valid is lowered only for an idle gap, so it gets one update per edge.
   task automatic send_word(input req_word_type w, output rsp_word_type predicted);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = heap_apply(w);
   endtask

   // Response side: check each accepted word against the oldest prediction,
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due_q.size() == 0) begin
            if (fault_count < 10) begin
               $display("unexpected word: key %0d status %0d fill %0d",
                        rsp_word.key_out, rsp_word.status, rsp_word.fill_count);
            end
            fault_count++;
         end else begin
            want = rsp_due_q.pop_front();
            if (rsp_word.key_out !== want.key_out || rsp_word.status !== want.status ||
                rsp_word.fill_count !== want.fill_count) begin
               if (fault_count < 10) begin
                  $display({"mismatch: expected key %0d status %0d fill %0d, ",
                            "got key %0d status %0d fill %0d"},
                           want.key_out, want.status, want.fill_count,
                           rsp_word.key_out, rsp_word.status, rsp_word.fill_count);
               end
               fault_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      rsp_word_type pred;

      // Empty heap and the no-op code, then the two key extremes.
      add_row(OP_PEEK,    KEY_JUNK, 1'b1, KEY_EMPTY, ST_EMPTY, 0);
      add_row(OP_EXTRACT, KEY_JUNK, 1'b1, KEY_EMPTY, ST_EMPTY, 0);
      add_row(OP_UNDEF,   KEY_EMPTY, 1'b1, KEY_NONE, ST_OK,    0);
      add_row(OP_INSERT,  KEY_MAX,  1'b1, KEY_NONE,  ST_OK,    1);
      add_row(OP_PEEK,    KEY_JUNK, 1'b1, KEY_MAX,   ST_OK,    1);
      add_row(OP_INSERT,  KEY_MIN,  1'b1, KEY_NONE,  ST_OK,    2);
      add_row(OP_PEEK,    KEY_EMPTY, 1'b1, KEY_MIN,  ST_OK,    2);
      add_row(OP_EXTRACT, KEY_JUNK, 1'b1, KEY_MIN,   ST_OK,    1);
      add_row(OP_EXTRACT, KEY_JUNK, 1'b1, KEY_MAX,   ST_OK,    0);
      add_row(OP_EXTRACT, KEY_JUNK, 1'b1, KEY_EMPTY, ST_EMPTY, 0);
      // Build 1,3,3,9,4: the first extract moves 4 to the root over two equal
      // children, so the left one must be taken.
      add_row(OP_INSERT,  32'sd1);
      add_row(OP_INSERT,  32'sd3);
      add_row(OP_INSERT,  32'sd3);
      add_row(OP_INSERT,  32'sd9);
      add_row(OP_INSERT,  32'sd4);
      add_row(OP_EXTRACT, KEY_JUNK);
      add_row(OP_EXTRACT, KEY_JUNK);
      add_row(OP_EXTRACT, KEY_JUNK);
      add_row(OP_EXTRACT, KEY_JUNK);
      add_row(OP_EXTRACT, KEY_JUNK);
      // no-op on a non-empty heap
      add_row(OP_INSERT,  -32'sd5);
      add_row(OP_UNDEF,   KEY_MAX);
      add_row(OP_PEEK,    KEY_JUNK);
      add_row(OP_EXTRACT, KEY_JUNK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words, no idling.
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].req, pred);
         rsp_due_q.push_back(dir_rows[i].known ? dir_rows[i].rsp : pred);
      end

      // Random words: alternate growing and draining phases across the
      // idle/stall patterns.
      for (int m = 0; m < N_MODES; m++) begin
         gap_pct   = GAP_PCT[m];
         stall_pct = STALL_PCT[m];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_word(rand_word((m % 2 == 0) ? 60 : 35), pred);
            rsp_due_q.push_back(pred);
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;

      // Drain owed words, then allow a full operation's worth of cycles for
      // anything stray.
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (fault_count == 0 && rsp_due_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
